### rtl/core/slc_pkg.sv
// Shared constants and control/status types of the lagged spike covariance block.
package slc_pkg;

	localparam int MAX_SPIKES = 4096;
	localparam int STEP_BITS  = 24;
	localparam int ADDR_W     = $clog2(MAX_SPIKES);
	localparam int CNT_W      = ADDR_W + 1;
	localparam int KEY_W      = STEP_BITS + 1;
	localparam int T_W        = 24;
	localparam int LAG_W      = 16;
	localparam int FRAC_W     = 32;
	localparam int COV_W      = 34;
	localparam int QUO_W      = 35;
	localparam int DIFF_W     = QUO_W + 1;
	localparam int DEN_W      = 2 * T_W;
	localparam int NUM_W      = 2 * CNT_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);

	localparam logic [QUO_W-1:0] TERM_CAP = QUO_W'(1) << (QUO_W - 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = T_W;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LAG   = 1'b1;

	localparam logic [T_W-1:0] TOTAL_RESET = T_W'(1048576);

	typedef struct packed {
		logic a_load;
		logic b_start;
		logic b_skip;
		logic probe;
		logic prep;
		logic div_q1;
		logic div_q2;
		logic take_q1;
		logic take_q2;
		logic res_load;
	} slc_cmd_t;

	typedef struct packed {
		logic b_room;
		logic search_more;
		logic lag_over;
		logic div_done;
	} slc_stat_t;

endpackage

### rtl/core/slc_if.sv
// Channel interfaces: spike input, result output and register write port.
interface slc_spike_if import slc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 mode;
	logic [STEP_BITS-1:0] spike_step;
	logic                 last;

	modport source (output valid, output mode, output spike_step, output last, input ready);
	modport sink (input valid, input mode, input spike_step, input last, output ready);
endinterface

interface slc_result_if import slc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [COV_W-1:0] covariance;
	logic [CNT_W-1:0]        coincidences;
	logic [CNT_W-1:0]        count_a;
	logic [CNT_W-1:0]        count_b;
	logic                    overflow;

	modport source (output valid, output covariance, output coincidences, output count_a,
		output count_b, output overflow, input ready);
	modport sink (input valid, input covariance, input coincidences, input count_a,
		input count_b, input overflow, output ready);
endinterface

interface slc_cfg_if import slc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/spike_lagged_covariance.sv
// Top level of the lagged spike-train covariance block.
// Load train A as spike steps (mode 0), then stream train B (mode 1); each B step plus the
// lag is looked up in A by a lower-bound binary search, one probe per cycle through the
// store's single registered read port. A B beat past the count limit is skipped without a
// search. The B beat marked last then runs the prep and start states and two runs of the
// one-bit-per-cycle restoring divider (58 steps each), for hits/(T-lag) and nA*nB/T^2,
// before the result state; with the lag not below T it runs only the prep, start and result
// states. The result waits in an output register while new spikes are taken, and a
// further closing B beat stalls until that register is free. The store needs no clearing
// pass after reset; register writes are always accepted and belong in idle periods.
module spike_lagged_covariance import slc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	slc_spike_if.sink     spk,
	slc_result_if.source  res,
	slc_cfg_if.sink       cfg
);

	slc_cmd_t  cmd;
	slc_stat_t stat;

	assign cfg.ready = 1'b1;

	slc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.spk_valid (spk.valid),
		.spk_ready (spk.ready),
		.spk_mode  (spk.mode),
		.spk_last  (spk.last),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	slc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.spike_step   (spk.spike_step),
		.spike_last   (spk.last),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.covariance   (res.covariance),
		.coincidences (res.coincidences),
		.count_a      (res.count_a),
		.count_b      (res.count_b),
		.overflow     (res.overflow)
	);

endmodule

### rtl/core/slc_div.sv
// Restoring divider, one quotient bit per cycle, truncated quotient capped at the term limit.
module slc_div import slc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [QUO_W-1:0] quo
);

	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;
	logic [QUO_W-1:0]     q_q;
	logic                 sticky_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_n;
	logic           ge;

	always_comb begin
		rem_sh = {rem_q, num_q[NUM_W-1]};
		ge     = rem_sh >= {1'b0, den_q};
		rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q    <= num;
			den_q    <= den;
			rem_q    <= '0;
			q_q      <= '0;
			sticky_q <= 1'b0;
		end else if (busy_q) begin
			num_q    <= {num_q[NUM_W-2:0], 1'b0};
			rem_q    <= rem_n[DEN_W-1:0];
			q_q      <= {q_q[QUO_W-2:0], ge};
			// any bit pushed out of the top saturates the term
			sticky_q <= sticky_q | q_q[QUO_W-1];
		end
	end

	assign done = done_q;
	assign quo  = (sticky_q || (q_q > TERM_CAP)) ? TERM_CAP : q_q;

endmodule

### rtl/core/slc_dp.sv
// Datapath: train A store, binary search, counters, ratio terms and result register.
module slc_dp import slc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  slc_cmd_t                cmd,
	output slc_stat_t               stat,
	input  logic [STEP_BITS-1:0]    spike_step,
	input  logic                    spike_last,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic signed [COV_W-1:0] covariance,
	output logic [CNT_W-1:0]        coincidences,
	output logic [CNT_W-1:0]        count_a,
	output logic [CNT_W-1:0]        count_b,
	output logic                    overflow
);

	logic [STEP_BITS-1:0] store_q [MAX_SPIKES];

	logic [T_W-1:0]   total_q;
	logic [LAG_W-1:0] lag_q;

	logic [CNT_W-1:0] a_count_q;
	logic [CNT_W-1:0] b_count_q;
	logic [CNT_W-1:0] hit_q;
	logic             a_ovf_q;
	logic             b_over_q;
	logic             a_closed_q;

	logic [KEY_W-1:0]     key_q;
	logic [CNT_W-1:0]     lo_q;
	logic [CNT_W-1:0]     hi_q;
	logic [ADDR_W-1:0]    mid_q;
	logic                 eq_q;
	logic [STEP_BITS-1:0] rd_q;

	logic [DEN_W-1:0]   tt_q;
	logic [2*CNT_W-1:0] ab_q;
	logic [T_W-1:0]     den1_q;
	logic [QUO_W-1:0]   q1_q;
	logic [QUO_W-1:0]   q2_q;

	logic signed [COV_W-1:0] cov_q;
	logic [CNT_W-1:0]        coin_q;
	logic [CNT_W-1:0]        ca_q;
	logic [CNT_W-1:0]        cb_q;
	logic                    ovf_out_q;

	logic [CNT_W-1:0] a_base;
	logic [CNT_W-1:0] lo_n;
	logic [CNT_W-1:0] hi_n;
	logic [CNT_W-1:0] span;
	logic [CNT_W-1:0] mid_n;
	logic             eq_n;
	logic             less;
	logic             more;
	logic             search_step;
	logic             lag_over;

	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] cov_lim;

	localparam logic signed [DIFF_W-1:0] COV_HI = DIFF_W'(1) << FRAC_W;
	localparam logic signed [DIFF_W-1:0] COV_LO = -COV_HI;

	// a new A train restarts the fill at entry zero
	assign a_base = a_closed_q ? '0 : a_count_q;

	always_comb begin
		less = {1'b0, rd_q} < key_q;
		if (cmd.b_start) begin
			lo_n = '0;
			hi_n = a_count_q;
			eq_n = 1'b0;
		end else if (less) begin
			lo_n = {1'b0, mid_q} + 1'b1;
			hi_n = hi_q;
			eq_n = eq_q;
		end else begin
			lo_n = lo_q;
			hi_n = {1'b0, mid_q};
			eq_n = rd_q == key_q[STEP_BITS-1:0] && !key_q[KEY_W-1];
		end
		span        = hi_n - lo_n;
		mid_n       = lo_n + (span >> 1);
		more        = lo_n < hi_n;
		search_step = cmd.b_start | cmd.probe;
	end

	assign lag_over = {{(T_W-LAG_W){1'b0}}, lag_q} >= total_q;

	always_comb begin
		stat.b_room      = b_count_q < CNT_W'(MAX_SPIKES);
		stat.search_more = more;
		stat.lag_over    = lag_over;
		stat.div_done    = div_done;
	end

	always_ff @(posedge clk) begin
		if (cmd.a_load && (a_base < CNT_W'(MAX_SPIKES))) begin
			store_q[a_base[ADDR_W-1:0]] <= spike_step;
		end
		if (search_step && more) begin
			rd_q <= store_q[mid_n[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RESET;
			lag_q      <= '0;
			a_count_q  <= '0;
			b_count_q  <= '0;
			hit_q      <= '0;
			a_ovf_q    <= 1'b0;
			b_over_q   <= 1'b0;
			a_closed_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOTAL: total_q <= cfg_data;
					REG_LAG:   lag_q   <= cfg_data[LAG_W-1:0];
					default:   ;
				endcase
			end
			if (cmd.a_load) begin
				if (a_closed_q) begin
					b_count_q <= '0;
					hit_q     <= '0;
					a_ovf_q   <= 1'b0;
					b_over_q  <= 1'b0;
				end
				if (a_base < CNT_W'(MAX_SPIKES)) begin
					a_count_q <= a_base + 1'b1;
				end else begin
					a_ovf_q <= 1'b1;
				end
				// a last beat closes the train, any other A beat leaves it open
				a_closed_q <= spike_last;
			end
			if (cmd.b_start) begin
				b_count_q <= b_count_q + 1'b1;
			end
			if (cmd.b_skip) begin
				b_over_q <= 1'b1;
			end
			// search closed: the entry where hi last settled decides the hit
			if (search_step && !more && eq_n) begin
				hit_q <= hit_q + 1'b1;
			end
			if (cmd.res_load) begin
				b_count_q <= '0;
				hit_q     <= '0;
				b_over_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.b_start) begin
			key_q <= KEY_W'(spike_step) + KEY_W'(lag_q);
		end
		if (search_step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			eq_q  <= eq_n;
			mid_q <= mid_n[ADDR_W-1:0];
		end
		if (cmd.prep) begin
			tt_q   <= {{T_W{1'b0}}, total_q} * {{T_W{1'b0}}, total_q};
			ab_q   <= {{CNT_W{1'b0}}, a_count_q} * {{CNT_W{1'b0}}, b_count_q};
			den1_q <= total_q - T_W'(lag_q);
		end
		if (cmd.take_q1) begin
			q1_q <= div_quo;
		end
		if (cmd.take_q2) begin
			q2_q <= div_quo;
		end
	end

	// numerator carries half the divisor so the quotient rounds half up
	always_comb begin
		div_start = cmd.div_q1 | cmd.div_q2;
		if (cmd.div_q2) begin
			div_num = {ab_q, {FRAC_W{1'b0}}} + NUM_W'(tt_q >> 1);
			div_den = tt_q;
		end else begin
			div_num = NUM_W'({hit_q, {FRAC_W{1'b0}}}) + NUM_W'(den1_q >> 1);
			div_den = DEN_W'(den1_q);
		end
	end

	slc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		diff = $signed({1'b0, q1_q}) - $signed({1'b0, q2_q});
		if (diff > COV_HI) begin
			cov_lim = COV_HI;
		end else if (diff < COV_LO) begin
			cov_lim = COV_LO;
		end else begin
			cov_lim = diff;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			cov_q     <= lag_over ? '0 : cov_lim[COV_W-1:0];
			coin_q    <= hit_q;
			ca_q      <= a_count_q;
			cb_q      <= b_count_q;
			ovf_out_q <= a_ovf_q | b_over_q | lag_over;
		end
	end

	assign covariance   = cov_q;
	assign coincidences = coin_q;
	assign count_a      = ca_q;
	assign count_b      = cb_q;
	assign overflow     = ovf_out_q;

endmodule

### rtl/core/slc_ctrl.sv
// Controller: sequences spike beats, search probes, the two divisions and result hand-off.
module slc_ctrl import slc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      spk_valid,
	output logic      spk_ready,
	input  logic      spk_mode,
	input  logic      spk_last,
	output logic      res_valid,
	input  logic      res_ready,
	input  slc_stat_t stat,
	output slc_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_PREP,
		S_START1,
		S_WAIT1,
		S_WAIT2,
		S_RESULT
	} state_t;

	state_t state_q;
	logic   last_q;
	logic   res_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (spk_valid) begin
					if (!spk_mode) begin
						cmd.a_load = 1'b1;
					end else if (stat.b_room) begin
						cmd.b_start = 1'b1;
					end else begin
						cmd.b_skip = 1'b1;
					end
				end
			end
			S_PROBE: cmd.probe = 1'b1;
			S_PREP:  cmd.prep = 1'b1;
			S_START1: begin
				if (!stat.lag_over) begin
					cmd.div_q1 = 1'b1;
				end
			end
			S_WAIT1: begin
				if (stat.div_done) begin
					cmd.take_q1 = 1'b1;
					cmd.div_q2  = 1'b1;
				end
			end
			S_WAIT2: begin
				if (stat.div_done) begin
					cmd.take_q2 = 1'b1;
				end
			end
			S_RESULT: begin
				if (!res_valid_q || res_ready) begin
					cmd.res_load = 1'b1;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (spk_valid && spk_mode) begin
						last_q <= spk_last;
						if (stat.b_room && stat.search_more) begin
							state_q <= S_PROBE;
						end else if (spk_last) begin
							state_q <= S_PREP;
						end
					end
				end
				S_PROBE: begin
					if (!stat.search_more) begin
						state_q <= last_q ? S_PREP : S_IDLE;
					end
				end
				S_PREP: state_q <= S_START1;
				S_START1: state_q <= stat.lag_over ? S_RESULT : S_WAIT1;
				S_WAIT1: begin
					if (stat.div_done) begin
						state_q <= S_WAIT2;
					end
				end
				S_WAIT2: begin
					if (stat.div_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					// hold until the output register is free
					if (!res_valid_q || res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign spk_ready = state_q == S_IDLE;
	assign res_valid = res_valid_q;

endmodule

### dv/testbench.sv
// Self-checking testbench for spike_lagged_covariance: directed table and random trains.
`timescale 1ns / 1ps
module testbench import slc_pkg::*; ();

	localparam logic MODE_A = 1'b0;
	localparam logic MODE_B = 1'b1;
	localparam int SETTLE = 200;
	localparam logic [STEP_BITS-1:0] STEP_MAX = '1;
	localparam longint COV_LIMIT = longint'(1) << FRAC_W;

	typedef struct packed {
		logic                 mode;
		logic [STEP_BITS-1:0] step;
		logic                 last;
	} spike_t;

	typedef struct packed {
		logic signed [COV_W-1:0] covariance;
		logic [CNT_W-1:0]        coincidences;
		logic [CNT_W-1:0]        count_a;
		logic [CNT_W-1:0]        count_b;
		logic                    overflow;
	} entry_t;

	typedef enum logic {ROW_SPIKE, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		spike_t                spike;
		bit                    typed;
		entry_t                want;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} row_t;

	logic clk;
	logic arst_n;
	slc_spike_if  spk();
	slc_result_if res();
	slc_cfg_if    cfg();

	spike_lagged_covariance u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.spk(spk),
		.res(res),
		.cfg(cfg)
	);

	// mirror of the block state and registers
	logic [STEP_BITS-1:0] a_steps [MAX_SPIKES];
	int unsigned n_a, n_b, n_hits;
	bit a_full, b_full, a_closed;
	logic [T_W-1:0] rec_len;
	logic [LAG_W-1:0] lag;

	entry_t pending_entries [$];
	int unsigned mismatches = 0;
	bit no_gaps = 1'b0;

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// round half up of num * 2^32 / den, capped at the term limit
	function automatic logic [QUO_W-1:0] q32_ratio(logic [63:0] num, logic [63:0] den);
		logic [127:0] q;
		q = (({64'd0, num} << FRAC_W) + {64'd0, den >> 1}) / {64'd0, den};
		return (q > 128'(TERM_CAP)) ? TERM_CAP : q[QUO_W-1:0];
	endfunction

	// lower-bound search over the stored A steps, hit on exact match
	function automatic bit found_in_a(logic [KEY_W-1:0] key);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = n_a;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if ({1'b0, a_steps[mid]} < key) lo = mid + 1;
			else hi = mid;
		end
		return (lo < n_a) && ({1'b0, a_steps[lo]} == key);
	endfunction

	function automatic bit track_spike(spike_t s, output entry_t e);
		longint d;
		logic [QUO_W-1:0] q1, q2;
		e = '0;
		if (s.mode == MODE_A) begin
			if (a_closed) begin
				a_closed = 1'b0;
				n_a = 0;
				n_b = 0;
				n_hits = 0;
				a_full = 1'b0;
				b_full = 1'b0;
			end
			if (n_a < MAX_SPIKES) begin
				a_steps[n_a] = s.step;
				n_a++;
			end else begin
				a_full = 1'b1;
			end
			if (s.last) a_closed = 1'b1;
			return 1'b0;
		end
		if (n_b < MAX_SPIKES) begin
			n_b++;
			if (found_in_a({1'b0, s.step} + KEY_W'(lag))) n_hits++;
		end else begin
			b_full = 1'b1;
		end
		if (!s.last) return 1'b0;
		d = 0;
		e.overflow = a_full || b_full || (lag >= rec_len);
		if (lag < rec_len) begin
			q1 = q32_ratio(64'(n_hits), 64'(rec_len) - 64'(lag));
			q2 = q32_ratio(64'(n_a) * 64'(n_b), 64'(rec_len) * 64'(rec_len));
			d = longint'(q1) - longint'(q2);
			if (d > COV_LIMIT) d = COV_LIMIT;
			if (d < -COV_LIMIT) d = -COV_LIMIT;
		end
		e.covariance = d[COV_W-1:0];
		e.coincidences = CNT_W'(n_hits);
		e.count_a = CNT_W'(n_a);
		e.count_b = CNT_W'(n_b);
		n_b = 0;
		n_hits = 0;
		b_full = 1'b0;
		return 1'b1;
	endfunction

	function automatic row_t spike_row(logic mode, logic [STEP_BITS-1:0] step, logic last);
		row_t r;
		r.kind = ROW_SPIKE;
		r.spike = spike_t'{mode, step, last};
		r.typed = 1'b0;
		r.want = '0;
		r.index = REG_TOTAL;
		r.data = '0;
		return r;
	endfunction

	// closing B beat with its result written out by hand
	function automatic row_t want_row(logic [STEP_BITS-1:0] step, longint cov, int hits,
			int na, int nb, logic ovf);
		row_t r;
		r = spike_row(MODE_B, step, 1'b1);
		r.typed = 1'b1;
		r.want = entry_t'{COV_W'(cov), CNT_W'(hits), CNT_W'(na), CNT_W'(nb), ovf};
		return r;
	endfunction

	function automatic row_t reg_row(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		row_t r;
		r = spike_row(MODE_A, '0, 1'b0);
		r.kind = ROW_REG;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	function automatic void check_field(string what, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_spike(spike_t s, bit typed = 1'b0, entry_t want = '0);
		int unsigned gap;
		entry_t e;
		gap = no_gaps ? 0 : idle_len();
		if (gap > 0) begin
			spk.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		spk.valid <= 1'b1;
		spk.mode <= s.mode;
		spk.spike_step <= s.step;
		spk.last <= s.last;
		do @(posedge clk); while (!spk.ready);
		if (track_spike(s, e))
			pending_entries.insert(pending_entries.size(), typed ? want : e);
	endtask

	// hold the input until every result is out and the search has settled
	task automatic drain();
		spk.valid <= 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		drain();
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (index == REG_TOTAL) rec_len = data;
		else lag = data[LAG_W-1:0];
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end

	initial begin
		int unsigned hold;
		res.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = idle_len();
			if (hold > 0) begin
				res.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			res.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 6))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		entry_t want;
		if (res.valid === 1'b1 && res.ready === 1'b1) begin
			if (pending_entries.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, got covariance %0d",
					$time, res.covariance);
				mismatches++;
			end else begin
				want = pending_entries.pop_front();
				check_field("covariance", want.covariance, res.covariance);
				check_field("coincidences", want.coincidences, res.coincidences);
				check_field("count_a", want.count_a, res.count_a);
				check_field("count_b", want.count_b, res.count_b);
				check_field("overflow", want.overflow, res.overflow);
			end
		end
	end

	initial begin
		row_t plan [$];
		logic [STEP_BITS-1:0] a_train [$];
		logic [STEP_BITS-1:0] base, step;
		int unsigned len, maxd, n_sent, pick, rec, lg;
		bit scrambled, open_a, lastless;

		arst_n <= 1'b0;
		spk.valid <= 1'b0;
		spk.mode <= MODE_A;
		spk.spike_step <= '0;
		spk.last <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.index <= REG_TOTAL;
		cfg.data <= '0;
		n_a = 0;
		n_b = 0;
		n_hits = 0;
		a_full = 1'b0;
		b_full = 1'b0;
		a_closed = 1'b0;
		rec_len = TOTAL_RESET;
		lag = '0;

		// registers at reset values: T = 2^20, no lag
		plan.insert(plan.size(), want_row(0, 0, 0, 0, 1, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, 0, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, 5, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, STEP_MAX, 1'b1));
		plan.insert(plan.size(), spike_row(MODE_B, 0, 1'b0));
		plan.insert(plan.size(), want_row(5, 8192, 2, 3, 2, 1'b0));
		plan.insert(plan.size(), want_row(STEP_MAX, 4096, 1, 3, 1, 1'b0));
		// shortest recording: both terms at full scale
		plan.insert(plan.size(), reg_row(REG_TOTAL, 1));
		plan.insert(plan.size(), reg_row(REG_LAG, 0));
		plan.insert(plan.size(), spike_row(MODE_A, 0, 1'b1));
		plan.insert(plan.size(), want_row(0, 0, 1, 1, 1, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_B, 0, 1'b0));
		plan.insert(plan.size(), want_row(1, -64'sd4294967296, 1, 1, 2, 1'b0));
		// longest recording and lag, unsorted A, keys past the step range
		plan.insert(plan.size(), reg_row(REG_TOTAL, STEP_MAX));
		plan.insert(plan.size(), reg_row(REG_LAG, 24'h00FFFF));
		plan.insert(plan.size(), spike_row(MODE_A, 100000, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, 65535, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, STEP_MAX, 1'b1));
		plan.insert(plan.size(), spike_row(MODE_B, 0, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_B, 34465, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_B, STEP_MAX, 1'b1));
		// lag not below the recording length
		plan.insert(plan.size(), reg_row(REG_TOTAL, 100));
		plan.insert(plan.size(), reg_row(REG_LAG, 100));
		plan.insert(plan.size(), want_row(0, 0, 0, 3, 1, 1'b1));
		// zero length recording, A and B interleaved
		plan.insert(plan.size(), reg_row(REG_TOTAL, 0));
		plan.insert(plan.size(), reg_row(REG_LAG, 0));
		plan.insert(plan.size(), spike_row(MODE_A, 7, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_B, 7, 1'b0));
		plan.insert(plan.size(), spike_row(MODE_A, 9, 1'b1));
		plan.insert(plan.size(), want_row(9, 0, 2, 2, 2, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) write_reg(plan[i].index, plan[i].data);
			else send_spike(plan[i].spike, plan[i].typed, plan[i].want);
		end

		for (int blk = 0; blk < 8; blk++) begin
			case ($urandom_range(0, 3))
				0: begin
					rec = $urandom_range(0, STEP_MAX);
					lg = $urandom_range(0, 16'hFFFF);
				end
				1: begin
					rec = $urandom_range(1, 64);
					lg = $urandom_range(0, rec - 1);
				end
				2: begin
					rec = $urandom_range(1000, 100000);
					lg = $urandom_range(0, 999);
				end
				default: begin
					rec = $urandom_range(0, 16'hFFFF);
					lg = $urandom_range(rec, 16'hFFFF);
				end
			endcase
			write_reg(REG_TOTAL, CFG_DATA_W'(rec));
			// upper data bits are don't-care for the lag register
			write_reg(REG_LAG, {8'($urandom), 16'(lg)});
			no_gaps = (blk == 5);
			n_sent = 0;
			while (n_sent < 30) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
				case ($urandom_range(0, 2))
					0: maxd = 3;
					1: maxd = 1000;
					default: maxd = 100000;
				endcase
				base = STEP_BITS'($urandom_range(0, STEP_MAX - len * maxd));
				scrambled = ($urandom_range(0, 6) == 0);
				open_a = ($urandom_range(0, 9) == 0);
				a_train.delete();
				for (int i = 0; i < len; i++) begin
					step = scrambled ? STEP_BITS'($urandom) : base;
					a_train.insert(a_train.size(), step);
					send_spike(spike_t'{MODE_A, step, (i == len - 1) && !open_a});
					base = base + STEP_BITS'($urandom_range(0, maxd));
				end
				n_sent += len;
				repeat ($urandom_range(1, 3)) begin
					len = $urandom_range(1, 20);
					lastless = ($urandom_range(0, 11) == 0);
					for (int i = 0; i < len; i++) begin
						pick = $urandom_range(0, 99);
						base = a_train[$urandom_range(0, a_train.size() - 1)];
						if (pick < 4) begin
							// stray A beat inside a B train
							send_spike(spike_t'{MODE_A, STEP_BITS'($urandom), 1'b0});
						end else begin
							if (pick < 65 && base >= lag) step = base - STEP_BITS'(lag);
							else if (pick < 75) step = STEP_MAX - STEP_BITS'($urandom_range(0, 3));
							else step = STEP_BITS'($urandom);
							send_spike(spike_t'{MODE_B, step, (i == len - 1) && !lastless});
						end
					end
					n_sent += len;
				end
			end
		end

		drain();
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule

### spike_lagged_covariance.f
rtl/core/slc_pkg.sv
rtl/core/slc_if.sv
rtl/core/slc_div.sv
rtl/core/slc_dp.sv
rtl/core/slc_ctrl.sv
rtl/core/spike_lagged_covariance.sv
dv/testbench.sv
